// ----- design/skyline_atlas_allocator_defines.svh -----
// assertion macros for the skyline atlas allocator
// expects clk_i and rst_ni in the scope of use
`ifndef SKYLINE_ATLAS_ALLOCATOR_DEFINES_SVH
`define SKYLINE_ATLAS_ALLOCATOR_DEFINES_SVH

`define SAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SAL_ASSERT_IMP(lbl, ante, cons, msg) \
  `SAL_ASSERT(lbl, (ante) |-> (cons), msg)

`define SAL_ASSERT_NXT(lbl, ante, cons, msg) \
  `SAL_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- design/sal_pkg.sv -----
// shared types, constants and helpers of the skyline atlas allocator
// no dependencies
package sal_pkg;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned REQ_W        = 12;
  localparam int unsigned CFG_W        = 13;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned WID_W        = 13;
  localparam int unsigned SUM_W        = 14;
  localparam int unsigned DIM_MIN      = 3;
  localparam int unsigned DIM_MAX      = 1 << COORD_BITS;
  localparam int unsigned DIM_RST      = 1024;
  localparam int unsigned MAX_SEGMENTS = 64;

  typedef enum logic [1:0] {
    ST_PLACED     = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'd1;

  typedef struct packed {
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [COORD_BITS-1:0] place_x;
    logic [COORD_BITS-1:0] place_y;
  } rsp_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] top;
    logic [WID_W-1:0]      wid;
  } seg_t;

  localparam seg_t SEG_RST = '{
    x:   COORD_BITS'(1),
    top: COORD_BITS'(1),
    wid: WID_W'(DIM_RST - 2)
  };

  typedef struct packed {
    logic a_shift;
    logic b_shift;
    logic commit;
    logic load_init;
  } chain_ctl_t;

  function automatic logic [WID_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v < CFG_W'(DIM_MIN)) begin
      r = WID_W'(DIM_MIN);
    end else if (v > CFG_W'(DIM_MAX)) begin
      r = WID_W'(DIM_MAX);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- design/sal_cell.sv -----
// one skyline cell: the live segment and a staging segment for the rebuilt list
// depends on sal_pkg
module sal_cell #(
  parameter sal_pkg::seg_t RST_SEG = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sal_pkg::chain_ctl_t ctl_i,
  input  sal_pkg::seg_t       init_i,
  input  sal_pkg::seg_t       a_i,
  input  sal_pkg::seg_t       b_i,
  output sal_pkg::seg_t       a_o,
  output sal_pkg::seg_t       b_o
);
  import sal_pkg::*;

  seg_t a_q, a_d;
  seg_t b_q, b_d;

  always_comb begin
    a_d = a_q;
    if (ctl_i.load_init) begin
      a_d = init_i;
    end else if (ctl_i.commit) begin
      a_d = b_q;
    end else if (ctl_i.a_shift) begin
      a_d = a_i;
    end
    b_d = ctl_i.b_shift ? b_i : b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= RST_SEG;
    end else begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

// ----- design/sal_chain.sv -----
// row of skyline cells: live segments rotate as a ring, staging segments shift in at the tail
// depends on sal_pkg and sal_cell
module sal_chain #(
  parameter int unsigned MAX_SEGMENTS = sal_pkg::MAX_SEGMENTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sal_pkg::chain_ctl_t ctl_i,
  input  sal_pkg::seg_t       init_i,
  input  sal_pkg::seg_t       push_i,
  output sal_pkg::seg_t       head_o
);
  import sal_pkg::*;

  seg_t a_w [MAX_SEGMENTS];
  seg_t b_w [MAX_SEGMENTS];

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    localparam int unsigned NXT = (k == MAX_SEGMENTS - 1) ? 0 : k + 1;
    sal_cell #(
      .RST_SEG((k == 0) ? SEG_RST : seg_t'('0))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .init_i ((k == 0) ? init_i : seg_t'('0)),
      .a_i    (a_w[NXT]),
      .b_i    ((k == MAX_SEGMENTS - 1) ? push_i : b_w[NXT]),
      .a_o    (a_w[k]),
      .b_o    (b_w[k])
    );
  end

  assign head_o = a_w[0];

endmodule

// ----- design/skyline_atlas_allocator.sv -----
// top level of the skyline atlas allocator: request sequencer around a ring of segment cells
// depends on sal_pkg, sal_chain and skyline_atlas_allocator_defines.svh
`include "skyline_atlas_allocator_defines.svh"

// One request at a time. The segment list lives in a ring of MAX_SEGMENTS cells that
// rotates one place per cycle while a request is searched or rebuilt, but holds while the
// new segment is inserted; it rotates past a single fit/merge unit at its head. The search
// makes one full rotation plus a compare step per live segment; the rebuild then takes one
// more rotation plus the inserted segment, a flush and padding of the staging row. A
// zero-sized request is answered without a search. The result sits in an output register
// while the next request is taken.
module skyline_atlas_allocator #(
  parameter int unsigned MAX_SEGMENTS = sal_pkg::MAX_SEGMENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sal_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sal_pkg::rsp_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sal_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sal_pkg::CFG_W-1:0]     cfg_data_i
);
  import sal_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned PW    = $clog2(MAX_SEGMENTS + 2);
  localparam logic [IW-1:0] LAST = IW'(MAX_SEGMENTS - 1);
  localparam logic [PW-1:0] PMAX = PW'(MAX_SEGMENTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_BUILD  = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_PAD    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WID_W-1:0]  aw_q, aw_d, ah_q, ah_d;
  logic [IW-1:0]     j_q, j_d, cand_q, cand_d, bi_q, bi_d;
  logic              act_q, act_d, fok_q, fok_d, bv_q, bv_d;
  logic              ins_q, ins_d, trim_q, trim_d, acc_v_q, acc_v_d;
  logic [PW-1:0]     npush_q, npush_d, nseg_q, nseg_d;
  logic              out_v_q, out_v_d;
  req_t              req_q, req_d;
  logic [COORD_BITS-1:0] y_q, y_d, fy_q, fy_d, cx_q, cx_d, px_q, px_d, py_q, py_d;
  logic [WID_W-1:0]  left_q, left_d, cw_q, cw_d, bw_q, bw_d;
  logic [SUM_W-1:0]  btop_q, btop_d;
  seg_t              acc_q, acc_d;
  rsp_t              rsp_q, rsp_d, out_q, out_d;

  chain_ctl_t        ctl;
  seg_t              head, push_seg, init_seg, item, new_seg;
  logic [SUM_W-1:0]  w_s, h_s, aw_m1, ah_m1, t_s, endx, shrink;
  logic [COORD_BITS-1:0] cur_y, ny;
  logic [WID_W-1:0]  cur_left;
  logic              idx_valid, start, cur_act, x_fail, y_fail, better, iv, adv, out_load;

  sal_chain #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .init_i (init_seg),
    .push_i (push_seg),
    .head_o (head)
  );

  assign w_s       = SUM_W'(req_q.req_width);
  assign h_s       = SUM_W'(req_q.req_height);
  assign aw_m1     = SUM_W'(aw_q) - SUM_W'(1);
  assign ah_m1     = SUM_W'(ah_q) - SUM_W'(1);
  assign idx_valid = CNT_W'(j_q) < cnt_q;
  assign out_load  = (state_q == S_RESP) && (!out_v_q || out_ready_i);

  // fit scan of the current candidate
  assign start    = (j_q == cand_q);
  assign cur_act  = start || act_q;
  assign cur_y    = start ? head.top : y_q;
  assign cur_left = start ? WID_W'(req_q.req_width) : left_q;
  assign x_fail   = start && ((SUM_W'(head.x) + w_s) > aw_m1);
  assign ny       = (head.top > cur_y) ? head.top : cur_y;
  assign y_fail   = (SUM_W'(ny) + h_s) > ah_m1;

  assign t_s    = SUM_W'(fy_q) + h_s;
  assign better = fok_q && (!bv_q || (t_s < btop_q) || ((t_s == btop_q) && (cw_q < bw_q)));

  assign endx    = SUM_W'(px_q) + w_s;
  assign shrink  = endx - SUM_W'(head.x);
  assign new_seg = '{x: px_q, top: COORD_BITS'(SUM_W'(py_q) + h_s),
                     wid: WID_W'(req_q.req_width)};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    aw_d     = aw_q;
    ah_d     = ah_q;
    j_d      = j_q;
    cand_d   = cand_q;
    bi_d     = bi_q;
    act_d    = act_q;
    fok_d    = fok_q;
    bv_d     = bv_q;
    ins_d    = ins_q;
    trim_d   = trim_q;
    acc_v_d  = acc_v_q;
    npush_d  = npush_q;
    nseg_d   = nseg_q;
    req_d    = req_q;
    y_d      = y_q;
    fy_d     = fy_q;
    cx_d     = cx_q;
    px_d     = px_q;
    py_d     = py_q;
    left_d   = left_q;
    cw_d     = cw_q;
    bw_d     = bw_q;
    btop_d   = btop_q;
    acc_d    = acc_q;
    rsp_d    = rsp_q;
    ctl      = '0;
    push_seg = '0;
    item     = head;
    iv       = 1'b0;
    adv      = 1'b1;
    init_seg = '{x: COORD_BITS'(1), top: COORD_BITS'(1), wid: WID_W'(0)};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if ((in_data_i.req_width == '0) || (in_data_i.req_height == '0)) begin
            rsp_d   = '{status: ST_NO_SPACE, place_x: '0, place_y: '0};
            state_d = S_RESP;
          end else begin
            cand_d  = '0;
            j_d     = '0;
            act_d   = 1'b0;
            fok_d   = 1'b0;
            bv_d    = 1'b0;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        ctl.a_shift = 1'b1;
        if (start) begin
          cx_d = head.x;
          cw_d = head.wid;
        end
        if (cur_act) begin
          if (x_fail || !idx_valid || y_fail) begin
            act_d = 1'b0;
          end else if (head.wid >= cur_left) begin
            act_d = 1'b0;
            fok_d = 1'b1;
            fy_d  = ny;
          end else begin
            act_d  = 1'b1;
            y_d    = ny;
            left_d = cur_left - head.wid;
          end
        end
        if (j_q == LAST) begin
          j_d     = '0;
          state_d = S_EVAL;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      S_EVAL: begin
        if (better) begin
          bv_d   = 1'b1;
          bi_d   = cand_q;
          btop_d = t_s;
          bw_d   = cw_q;
          px_d   = cx_q;
          py_d   = fy_q;
        end
        act_d = 1'b0;
        fok_d = 1'b0;
        j_d   = '0;
        if (CNT_W'(cand_q) == cnt_q - CNT_W'(1)) begin
          if (better || bv_q) begin
            ins_d   = 1'b0;
            trim_d  = 1'b1;
            acc_v_d = 1'b0;
            npush_d = '0;
            state_d = S_BUILD;
          end else begin
            rsp_d   = '{status: ST_NO_SPACE, place_x: '0, place_y: '0};
            state_d = S_RESP;
          end
        end else begin
          cand_d  = cand_q + IW'(1);
          state_d = S_SEARCH;
        end
      end
      S_BUILD: begin
        if (j_q < bi_q) begin
          iv = 1'b1;
        end else if (!ins_q) begin
          item  = new_seg;
          iv    = 1'b1;
          adv   = 1'b0;
          ins_d = 1'b1;
        end else if (idx_valid) begin
          if (trim_q && (SUM_W'(head.x) < endx)) begin
            if (SUM_W'(head.wid) > shrink) begin
              iv       = 1'b1;
              item.x   = COORD_BITS'(endx);
              item.wid = WID_W'(SUM_W'(head.wid) - shrink);
              trim_d   = 1'b0;
            end
          end else begin
            iv     = 1'b1;
            trim_d = 1'b0;
          end
        end
        // merge neighbors of equal height, emit the finished one
        if (iv) begin
          if (!acc_v_q) begin
            acc_d   = item;
            acc_v_d = 1'b1;
          end else if (acc_q.top == item.top) begin
            acc_d.wid = acc_q.wid + item.wid;
          end else begin
            ctl.b_shift = 1'b1;
            push_seg    = acc_q;
            npush_d     = npush_q + PW'(1);
            acc_d       = item;
          end
        end
        ctl.a_shift = adv;
        if (adv) begin
          if (j_q == LAST) begin
            j_d     = '0;
            state_d = S_FLUSH;
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      S_FLUSH: begin
        ctl.b_shift = 1'b1;
        push_seg    = acc_q;
        npush_d     = npush_q + PW'(1);
        nseg_d      = npush_q + PW'(1);
        state_d     = S_PAD;
      end
      S_PAD: begin
        if (nseg_q > PMAX) begin
          rsp_d   = '{status: ST_TABLE_FULL, place_x: '0, place_y: '0};
          state_d = S_RESP;
        end else if (npush_q < PMAX) begin
          ctl.b_shift = 1'b1;
          npush_d     = npush_q + PW'(1);
        end else begin
          ctl.commit = 1'b1;
          cnt_d      = CNT_W'(nseg_q);
          rsp_d      = '{status: ST_PLACED, place_x: px_q, place_y: py_q};
          state_d    = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATLAS_WIDTH: begin
          aw_d          = clamp_dim(cfg_data_i);
          init_seg.wid  = clamp_dim(cfg_data_i) - WID_W'(2);
          ctl.load_init = 1'b1;
          cnt_d         = CNT_W'(1);
        end
        CFG_ATLAS_HEIGHT: begin
          ah_d = clamp_dim(cfg_data_i);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_d   = out_load ? rsp_q : out_q;
    out_v_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_W'(1);
      aw_q    <= WID_W'(DIM_RST);
      ah_q    <= WID_W'(DIM_RST);
      j_q     <= '0;
      cand_q  <= '0;
      bi_q    <= '0;
      act_q   <= 1'b0;
      fok_q   <= 1'b0;
      bv_q    <= 1'b0;
      ins_q   <= 1'b0;
      trim_q  <= 1'b0;
      acc_v_q <= 1'b0;
      npush_q <= '0;
      nseg_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      aw_q    <= aw_d;
      ah_q    <= ah_d;
      j_q     <= j_d;
      cand_q  <= cand_d;
      bi_q    <= bi_d;
      act_q   <= act_d;
      fok_q   <= fok_d;
      bv_q    <= bv_d;
      ins_q   <= ins_d;
      trim_q  <= trim_d;
      acc_v_q <= acc_v_d;
      npush_q <= npush_d;
      nseg_q  <= nseg_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    y_q    <= y_d;
    fy_q   <= fy_d;
    cx_q   <= cx_d;
    px_q   <= px_d;
    py_q   <= py_d;
    left_q <= left_d;
    cw_q   <= cw_d;
    bw_q   <= bw_d;
    btop_q <= btop_d;
    acc_q  <= acc_d;
    rsp_q  <= rsp_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `SAL_ASSERT(a_cnt_range, (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
  `SAL_ASSERT_IMP(a_commit_fits, ctl.commit, nseg_q <= PMAX, "commit of an oversized segment list")
  `SAL_ASSERT_NXT(a_busy_after_take, in_valid_i && in_ready_o, state_q != S_IDLE, "transaction taken but sequencer idle")
  `SAL_ASSERT_IMP(a_build_has_best, state_q == S_BUILD, bv_q, "rebuild without a chosen segment")

endmodule
